[rtl/per_key_event_stats_table_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the per-key event statistics table
// Implication checks sampled on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef PER_KEY_EVENT_STATS_TABLE_MACROS_SVH
`define PER_KEY_EVENT_STATS_TABLE_MACROS_SVH

// Same-cycle implication.
`define PKES_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PKES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pkes_pkg.sv]
// ---------------------------------------------------------------------------
// pkes_pkg
// Shared types, sizes and the slot hash for the per-key event statistics table.
// ---------------------------------------------------------------------------
package pkes_pkg;

	localparam int ENTRIES = 1024;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t             LAST_IDX    = IDX_W'(ENTRIES - 1);
	localparam logic [IDX_W:0]   ENTRIES_EXT = (IDX_W + 1)'(ENTRIES);

	typedef enum logic [1:0] {
		ST_UPDATED  = 2'd0,
		ST_INSERTED = 2'd1,
		ST_DROPPED  = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] process_key;
		logic [63:0] event_time;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] event_count;
		logic [63:0] gap_total;
		logic [63:0] gap_added;
	} res_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [63:0] count;
		logic [63:0] last_time;
		logic [63:0] gap_total;
	} entry_t;

	typedef struct packed {
		idx_t   rd_addr;
		logic   wr_en;
		idx_t   wr_addr;
		entry_t wr_data;
	} mem_cmd_t;

	// Fold the key down to a home slot in range [0, ENTRIES).
	function automatic idx_t home_slot(input logic [31:0] key);
		logic [31:0]    x;
		logic [IDX_W:0] h;
		x = key ^ (key >> 16);
		x = x ^ (x >> 8);
		h = {1'b0, x[IDX_W-1:0]};
		if (h >= ENTRIES_EXT) begin
			h = h - ENTRIES_EXT;
		end
		return h[IDX_W-1:0];
	endfunction

endpackage

[rtl/pkes_table.sv]
// ---------------------------------------------------------------------------
// pkes_table
// Record store: one synchronous write port, one read port registered once.
// ---------------------------------------------------------------------------
module pkes_table (
	input  logic              clk,
	input  pkes_pkg::mem_cmd_t cmd,
	output pkes_pkg::entry_t   rd_data
);

	pkes_pkg::entry_t mem [pkes_pkg::ENTRIES];

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
		rd_data <= mem[cmd.rd_addr];
	end

endmodule

[rtl/pkes_ctrl.sv]
// ---------------------------------------------------------------------------
// pkes_ctrl
// Clearing pass, open-addressing probe and read-modify-write of one record.
// ---------------------------------------------------------------------------
`include "per_key_event_stats_table_macros.svh"

module pkes_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  pkes_pkg::req_t     req,
	input  logic               out_free,
	output logic               res_push,
	output pkes_pkg::res_t     res_data,
	output pkes_pkg::mem_cmd_t cmd,
	input  pkes_pkg::entry_t   rd_data
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_CALC,
		S_WRITE
	} state_t;

	state_t             state_q;
	pkes_pkg::idx_t     clr_idx_q;
	pkes_pkg::idx_t     probe_idx_q;
	pkes_pkg::idx_t     probes_q;
	logic [31:0]        key_q;
	logic [63:0]        time_q;
	pkes_pkg::status_t  status_q;
	logic [63:0]        count_q;
	logic [63:0]        last_q;
	logic [63:0]        gtot_q;
	logic [63:0]        gap_q;

	pkes_pkg::idx_t next_idx;
	logic           hit;
	logic           empty;
	logic [63:0]    gtot_new;

	assign next_idx = (probe_idx_q == pkes_pkg::LAST_IDX) ? '0 : probe_idx_q + 1'b1;
	assign hit      = rd_data.valid && (rd_data.key == key_q);
	assign empty    = !rd_data.valid;
	assign gtot_new = gtot_q + gap_q;

	assign req_stall = (state_q != S_IDLE);
	assign res_push  = (state_q == S_WRITE) && out_free;

	always_comb begin
		res_data.status      = status_q;
		res_data.event_count = count_q;
		res_data.gap_total   = gtot_new;
		res_data.gap_added   = gap_q;
	end

	always_comb begin
		cmd.rd_addr           = probe_idx_q;
		cmd.wr_en             = 1'b0;
		cmd.wr_addr           = probe_idx_q;
		cmd.wr_data.valid     = 1'b1;
		cmd.wr_data.key       = key_q;
		cmd.wr_data.count     = count_q;
		cmd.wr_data.last_time = time_q;
		cmd.wr_data.gap_total = gtot_new;
		unique case (state_q)
			S_CLEAR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = clr_idx_q;
				cmd.wr_data = '0;
			end
			S_IDLE: begin
				cmd.rd_addr = pkes_pkg::home_slot(req.process_key);
			end
			S_LOOK: begin
				if (!hit && !empty) begin
					cmd.rd_addr = next_idx;
				end
			end
			S_CALC: begin
			end
			S_WRITE: begin
				cmd.wr_en = out_free && (status_q != pkes_pkg::ST_DROPPED);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			probe_idx_q <= '0;
			probes_q    <= '0;
			key_q       <= '0;
			time_q      <= '0;
			status_q    <= pkes_pkg::ST_UPDATED;
			count_q     <= '0;
			last_q      <= '0;
			gtot_q      <= '0;
			gap_q       <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == pkes_pkg::LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						key_q       <= req.process_key;
						time_q      <= req.event_time;
						probe_idx_q <= pkes_pkg::home_slot(req.process_key);
						probes_q    <= '0;
						state_q     <= S_LOOK;
					end
				end
				S_LOOK: begin
					priority if (hit) begin
						status_q <= pkes_pkg::ST_UPDATED;
						count_q  <= rd_data.count + 64'd1;
						last_q   <= rd_data.last_time;
						gtot_q   <= rd_data.gap_total;
						state_q  <= S_CALC;
					end else if (empty) begin
						status_q <= pkes_pkg::ST_INSERTED;
						count_q  <= 64'd1;
						gtot_q   <= '0;
						gap_q    <= '0;
						state_q  <= S_WRITE;
					end else if (probes_q == pkes_pkg::LAST_IDX) begin
						// every slot holds another key: drop
						status_q <= pkes_pkg::ST_DROPPED;
						count_q  <= '0;
						gtot_q   <= '0;
						gap_q    <= '0;
						state_q  <= S_WRITE;
					end else begin
						probes_q    <= probes_q + 1'b1;
						probe_idx_q <= next_idx;
					end
				end
				S_CALC: begin
					gap_q   <= (last_q != 64'd0) ? (time_q - last_q) : 64'd0;
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PKES_ASSERT_NOW(a_write_phase, cmd.wr_en, (state_q == S_CLEAR) || (state_q == S_WRITE), "table written outside clear or write phase")
	`PKES_ASSERT_NOW(a_drop_no_write, (state_q == S_WRITE) && (status_q == pkes_pkg::ST_DROPPED), !cmd.wr_en, "dropped request wrote the table")
	`PKES_ASSERT_NEXT(a_insert_path, (state_q == S_LOOK) && empty, (state_q == S_WRITE) && (status_q == pkes_pkg::ST_INSERTED), "empty slot did not lead to insert")
	`PKES_ASSERT_NEXT(a_hit_path, (state_q == S_LOOK) && hit, (state_q == S_CALC) && (status_q == pkes_pkg::ST_UPDATED), "matching slot did not lead to update")

endmodule

[rtl/per_key_event_stats_table.sv]
// ---------------------------------------------------------------------------
// per_key_event_stats_table
// Per-key event count, last timestamp and accumulated gap in a hashed table.
// ---------------------------------------------------------------------------
// After reset the block sweeps all ENTRIES (1024) slots of the record
// memory clear and holds req_stall high meanwhile. Each request then probes
// in the LOOK state and goes through CALC and WRITE on an update, straight
// to WRITE on an insert, and to WRITE after probing every slot on a drop:
// the key hashes to a home slot and linear probing advances one slot per
// cycle through the single read port of the record memory, so one slot is
// probed unless keys collide. Only one request is in work at a time; the
// result register lets a new request enter while the last result still waits under res_stall.
module per_key_event_stats_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pkes_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_stall,
	output pkes_pkg::res_t res
);

	pkes_pkg::mem_cmd_t cmd;
	pkes_pkg::entry_t   rd_data;
	pkes_pkg::res_t     res_data;
	pkes_pkg::res_t     res_q;
	logic               res_valid_q;
	logic               res_push;
	logic               out_free;

	// The result register is free when empty or being taken this cycle.
	assign out_free = !res_valid_q || !res_stall;

	pkes_table u_table (
		.clk     (clk),
		.cmd     (cmd),
		.rd_data (rd_data)
	);

	pkes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.out_free  (out_free),
		.res_push  (res_push),
		.res_data  (res_data),
		.cmd       (cmd),
		.rd_data   (rd_data)
	);

	// Hold the result until taken; load a new one when pushed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_push) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q <= res_data;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[tb/per_key_event_stats_table_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// per_key_event_stats_table_tb
// Drives process events into the statistics table and checks every result
// against a keyed record store kept in the testbench: directed corner
// events, random traffic over a growing key set, a fill to capacity, then
// drops and long probe chains on a full table, under random bursts and stalls.
// ---------------------------------------------------------------------------
module per_key_event_stats_table_tb;

	localparam int STALL_LIMIT  = 20000;  // cycles with no handshake before giving up
	localparam int HOLD_CYCLES  = 500;    // long result hold-off, forces req_stall
	localparam int HOLD_AFTER   = 300;    // results seen before the hold-off starts
	localparam int RANDOM_ITEMS = 400;
	localparam int FULL_ITEMS   = 150;

	// Expected-result store and per-key record mirror.
	class stats_scoreboard;
		typedef struct packed {
			logic [63:0] count;
			logic [63:0] last_stamp;
			logic [63:0] gap_sum;
		} record_t;

		record_t          records [bit [31:0]];
		int unsigned      used;
		pkes_pkg::res_t   expected_q[$];
		int unsigned      errors;
		int unsigned      n_requests, n_results;
		int unsigned      n_updated, n_inserted, n_dropped, n_zero_stamp, n_wrapped;

		function new();
			used = 0;
			errors = 0;
			n_requests = 0;
			n_results = 0;
			n_updated = 0;
			n_inserted = 0;
			n_dropped = 0;
			n_zero_stamp = 0;
			n_wrapped = 0;
		endfunction

		// Apply one accepted request to the mirror and queue its result.
		function void note_request(pkes_pkg::req_t r);
			pkes_pkg::res_t exp_res;
			record_t        rec;
			logic [63:0]    gap;
			exp_res = '0;
			gap = '0;
			n_requests++;
			if (records.exists(r.process_key)) begin
				rec = records[r.process_key];
				rec.count = rec.count + 64'd1;
				if (rec.last_stamp != 64'd0) begin
					gap = r.event_time - rec.last_stamp;
					rec.gap_sum = rec.gap_sum + gap;
					if (r.event_time < rec.last_stamp)
						n_wrapped++;
				end else begin
					n_zero_stamp++;
				end
				rec.last_stamp = r.event_time;
				records[r.process_key] = rec;
				exp_res.status      = pkes_pkg::ST_UPDATED;
				exp_res.event_count = rec.count;
				exp_res.gap_total   = rec.gap_sum;
				exp_res.gap_added   = gap;
				n_updated++;
			end else if (used < pkes_pkg::ENTRIES) begin
				rec.count = 64'd1;
				rec.last_stamp = r.event_time;
				rec.gap_sum = '0;
				records[r.process_key] = rec;
				used++;
				exp_res.status      = pkes_pkg::ST_INSERTED;
				exp_res.event_count = 64'd1;
				n_inserted++;
			end else begin
				// Table full: state untouched, all counters read as zero.
				exp_res.status = pkes_pkg::ST_DROPPED;
				n_dropped++;
			end
			expected_q.push_back(exp_res);
		endfunction

		function void check_result(pkes_pkg::res_t got);
			pkes_pkg::res_t want;
			n_results++;
			if (expected_q.size() == 0) begin
				$error("result with no request pending: status %0d count %0h",
					got.status, got.event_count);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status) begin
				$error("status expected %0d got %0d", want.status, got.status);
				errors++;
			end
			if (got.event_count !== want.event_count) begin
				$error("event_count expected %0h got %0h", want.event_count, got.event_count);
				errors++;
			end
			if (got.gap_total !== want.gap_total) begin
				$error("gap_total expected %0h got %0h", want.gap_total, got.gap_total);
				errors++;
			end
			if (got.gap_added !== want.gap_added) begin
				$error("gap_added expected %0h got %0h", want.gap_added, got.gap_added);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	pkes_pkg::req_t req       = '0;
	logic           res_valid;
	logic           res_stall = 1'b0;
	pkes_pkg::res_t res;

	stats_scoreboard sb;

	// Generator-side view of which keys will be in the table.
	bit [31:0]   known_keys[$];
	bit          key_seen [bit [31:0]];
	logic [63:0] stamp_clock;
	int          burst_left;
	int          idle_left;

	per_key_event_stats_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Flip the same bit pattern in byte 3 and byte 1: the key folds to the
	// same home slot, so these build probe chains.
	function automatic bit [31:0] collide(bit [31:0] base, bit [7:0] d);
		return base ^ {d, 8'h00, d, 8'h00};
	endfunction

	function automatic bit [31:0] fresh_key();
		bit [31:0] k;
		do begin
			if (known_keys.size() != 0 && $urandom_range(0, 3) == 0)
				k = collide(known_keys[$urandom_range(0, known_keys.size() - 1)],
					8'($urandom_range(1, 255)));
			else
				k = $urandom;
		end while (key_seen.exists(k));
		return k;
	endfunction

	function automatic bit [31:0] known_key();
		return known_keys[$urandom_range(0, known_keys.size() - 1)];
	endfunction

	// Mostly forward-moving timestamps, with zero, all-ones, fully random
	// and backward steps mixed in.
	function automatic logic [63:0] next_stamp();
		case ($urandom_range(0, 15))
			0: return 64'd0;
			1: return {$urandom, $urandom};
			2: return '1;
			3: begin
				stamp_clock = stamp_clock - 64'($urandom_range(1, 100000));
				return stamp_clock;
			end
			default: begin
				stamp_clock = stamp_clock + 64'($urandom_range(1, 50000));
				return stamp_clock;
			end
		endcase
	endfunction

	// Offer one request and hold it until accepted; idle between bursts.
	task automatic issue(input bit [31:0] key, input logic [63:0] stamp);
		pkes_pkg::req_t item;
		item.process_key = key;
		item.event_time  = stamp;
		if (idle_left > 0) begin
			req_valid <= 1'b0;
			repeat (idle_left) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!(req_valid && !req_stall));
		sb.note_request(item);
		if (!key_seen.exists(key) && known_keys.size() < pkes_pkg::ENTRIES) begin
			key_seen[key] = 1'b1;
			known_keys.push_back(key);
		end
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 32);
			idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
		end else begin
			idle_left = 0;
		end
	endtask

	// Stimulus.
	initial begin
		bit [31:0] base;
		int        pick;
		sb = new();
		stamp_clock = {$urandom, $urandom};
		burst_left = $urandom_range(1, 32);
		idle_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Zero key, zero stamp: the next hit must add no gap.
		issue(32'h0000_0000, 64'd0);
		issue(32'h0000_0000, 64'd5);
		issue(32'h0000_0000, 64'd12);
		// All-ones key and stamp, then step backwards so the gap wraps.
		issue(32'hFFFF_FFFF, '1);
		issue(32'hFFFF_FFFF, 64'd3);
		issue(32'hFFFF_FFFF, 64'd0);
		issue(32'hFFFF_FFFF, 64'd100);
		issue(32'h0000_0000, 64'd7);
		issue(32'h0000_0000, 64'd0);
		issue(32'h0000_0000, 64'd1);
		// Three keys sharing one home slot; hit them in reverse order.
		base = 32'h1234_5678;
		issue(base, 64'd1000);
		issue(collide(base, 8'h5A), 64'd2000);
		issue(collide(base, 8'hC3), 64'd3000);
		issue(collide(base, 8'hC3), 64'd3500);
		issue(collide(base, 8'h5A), 64'd2600);
		issue(base, 64'd900);
		// Alternating bit patterns on both fields.
		issue(32'hAAAA_AAAA, 64'h5555_5555_5555_5555);
		issue(32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		issue(32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
		issue(32'h5555_5555, 64'h5555_5555_5555_5555);

		// Random traffic: mostly hits on known keys, some new and colliding keys.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5)
				issue(known_key(), next_stamp());
			else if (pick <= 8)
				issue(fresh_key(), next_stamp());
			else
				issue($urandom, next_stamp());
		end

		// Fill the table to capacity, with hits interleaved.
		while (known_keys.size() < pkes_pkg::ENTRIES) begin
			if ($urandom_range(0, 4) == 0)
				issue(known_key(), next_stamp());
			else
				issue(fresh_key(), next_stamp());
		end

		// Full table: unknown keys drop, known keys still update.
		for (int n = 0; n < FULL_ITEMS; n++) begin
			if ($urandom_range(0, 1) == 0)
				issue(fresh_key(), next_stamp());
			else
				issue(known_key(), next_stamp());
		end
		req_valid <= 1'b0;

		// Drain, then give a stray result time to show up.
		while (sb.pending() != 0) @(posedge clk);
		repeat (pkes_pkg::ENTRIES + 16) @(posedge clk);

		$display("Ran %0d requests: %0d updates, %0d inserts, %0d drops on a %0d-slot table.",
			sb.n_requests, sb.n_updated, sb.n_inserted, sb.n_dropped, pkes_pkg::ENTRIES);
		$display("Saw %0d hits on a zero stamp, %0d wrapped backward gaps, one %0d-cycle hold.",
			sb.n_zero_stamp, sb.n_wrapped, HOLD_CYCLES);
		if (sb.errors == 0)
			$display("per_key_event_stats_table verification clean");
		else
			$display("per_key_event_stats_table verification failed");
		$finish;
	end

	// Result side: check each accepted result, stall in random windows, and
	// hold off once for a long stretch so the block backs up into req_stall.
	initial begin
		int  window;
		int  mode;
		bit  held;
		window = 0;
		mode = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall)
				sb.check_result(res);
			if (!held && sb.n_results >= HOLD_AFTER) begin
				held = 1'b1;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				window = 0;
			end
			if (window == 0) begin
				window = $urandom_range(16, 96);
				mode = $urandom_range(0, 2);
			end
			window--;
			case (mode)
				0:       res_stall <= 1'b0;
				1:       res_stall <= ($urandom_range(0, 3) == 0);
				default: res_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Watchdog: end the run if no handshake happens for too long.
	initial begin
		int idle_run;
		idle_run = 0;
		while (idle_run < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("Timed out after %0d cycles with no handshake.", STALL_LIMIT);
		$display("per_key_event_stats_table verification failed");
		$finish;
	end

endmodule
